>>> src/lru_key_value_cache_defines.svh
// Assertion macros shared by the cache RTL.
// They expand to nothing when SYNTH is defined.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define LKVC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LKVC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> src/lkvc_pkg.sv
package lkvc_pkg;

   // Width and reset of the capacity register.
   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;

   // Operation codes.
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   // One request item.
   typedef struct packed {
      logic               func;
      logic signed [31:0] lookup_key;
      logic signed [31:0] write_value;
   } req_type;

   // One response item.
   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
   } rsp_type;

endpackage

>>> src/lkvc_ram.sv
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read that holds while not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Each request item is a get or a put; every item yields exactly one
// response item, and a new item can be taken every clock cycle while the
// response side is not stalled. An item passes through the input register,
// where all ENTRIES key registers are compared in parallel and the recency
// ranks are updated, then through the value RAM's registered read and the
// response register. The store starts empty after reset, with no clearing
// pass. The capacity register limits occupancy (0 acts as 1, values above
// ENTRIES act as ENTRIES) and should be written only while the cache is idle.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lkvc_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lkvc_pkg::rsp_type      rsp_data,
   input  logic                   csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_wr_data
);

   import lkvc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Configuration.
   logic [CAP_W-1:0] cap_ff;

   // Input stage.
   logic    in_valid_ff;
   req_type in_ff;

   // Store state.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]        key_ff  [ENTRIES];
   logic [31:0]        key_in  [ENTRIES];
   logic [IDX_W-1:0]   rank_ff [ENTRIES];
   logic [IDX_W-1:0]   rank_in [ENTRIES];
   logic [CNT_W-1:0]   occ_ff, occ_in, occ_m1;

   // Response stage.
   logic        rsp_valid_ff;
   logic        found_ff;
   logic        get_hit_ff;
   logic [31:0] ram_rd_data;

   // Lookup and replacement decode.
   logic               advance;
   logic               do_op;
   logic               is_put;
   logic [ENTRIES-1:0] hit_vec;
   logic               hit;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   hit_rank;
   logic [ENTRIES-1:0] victim_vec;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] first_free_vec;
   logic [ENTRIES-1:0] slot_vec;
   logic [IDX_W-1:0]   slot_idx;
   logic [CMP_W-1:0]   eff_cap;
   logic               evict;

   // Handshake: the input register empties whenever the response side moves.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign do_op     = in_valid_ff && advance;
   assign is_put    = (in_ff.func == FUNC_PUT);

   // Effective capacity, clamped to one .. ENTRIES.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign evict  = (CMP_W'(occ_ff) >= eff_cap);
   assign occ_m1 = occ_ff - 1'b1;

   // Parallel key compare; the least recent entry holds rank occupancy - 1.
   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (key_ff[i] == in_ff.lookup_key);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == occ_m1[IDX_W-1:0]);
         if (hit_vec[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
      end
   end

   assign hit = |hit_vec;

   // Lowest free entry, or the victim when the store is full.
   assign free_vec       = ~valid_ff;
   assign first_free_vec = free_vec & (~free_vec + 1'b1);
   assign slot_vec       = evict ? victim_vec : first_free_vec;

   always_comb begin
      slot_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_vec[i]) begin
            slot_idx = slot_idx | IDX_W'(i);
         end
      end
   end

   // Next store state: touch on a hit, insert as most recent on a put miss.
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      rank_in  = rank_ff;
      occ_in   = occ_ff;
      if (do_op) begin
         if (hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (hit_vec[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
         end else if (is_put) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_vec[i]) begin
                  valid_in[i] = 1'b1;
                  key_in[i]   = in_ff.lookup_key;
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            if (!evict) begin
               occ_in = occ_ff + 1'b1;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_W'(CAP_RESET);
         in_valid_ff  <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         rank_ff  <= rank_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
      if (do_op) begin
         found_ff   <= hit;
         get_hit_ff <= hit && !is_put;
      end
      key_ff <= key_in;
   end

   // Value store: a put writes its entry, a get hit reads it.
   lkvc_ram #(
      .WIDTH (32),
      .DEPTH (ENTRIES)
   ) value_ram (
      .clock   (clock),
      .wr_en   (do_op && is_put),
      .wr_addr (hit ? hit_idx : slot_idx),
      .wr_data (in_ff.write_value),
      .rd_en   (do_op && hit && !is_put),
      .rd_addr (hit_idx),
      .rd_data (ram_rd_data)
   );

   // Response item.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.found      = found_ff;
   assign rsp_data.read_value = get_hit_ff ? ram_rd_data : '0;

   // Checks.
   `LKVC_ASSERT_IMPL(a_occ_matches_valid, clock, reset, 1'b1,
      $countones(valid_ff) == 32'(occ_ff), "occupancy differs from valid entries")
   `LKVC_ASSERT_IMPL(a_single_hit, clock, reset, in_valid_ff,
      $onehot0(hit_vec), "key present in more than one entry")
   `LKVC_ASSERT_NEXT(a_put_hit_keeps_occ, clock, reset, do_op && hit,
      $stable(occ_ff), "update of a present key changed occupancy")
   `LKVC_ASSERT_NEXT(a_hit_reports_found, clock, reset, do_op && hit,
      rsp_valid_ff && found_ff, "hit not reported as found")

endmodule
